FILE: rtl/ppr_pkg.sv
package ppr_pkg;

  localparam int COORD_W     = 32;
  localparam int LEN_W       = 31;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int PROD_W      = 2 * COORD_W;
  localparam int RND_W       = 34;
  localparam int ACC_W       = 35;
  localparam int SAT_W       = 40;
  localparam int NUM_AXES    = 3;
  localparam int MAT_DEPTH   = 9;
  localparam int MAT_FRAC    = 30;
  localparam int PIVOT_BASE  = 9;
  localparam int PIVOT_DEPTH = 3;
  localparam int BOX_RESET_UNITS = 100;

  localparam logic [COORD_W-1:0] MAT_ONE = 32'h4000_0000;
  localparam logic signed [PROD_W-1:0] RND_BIAS = 64'sd1 <<< (MAT_FRAC - 1);

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_POINT = 1'b1;

  localparam logic [1:0] REG_BOX_X = 2'd0;
  localparam logic [1:0] REG_BOX_Y = 2'd1;
  localparam logic [1:0] REG_BOX_Z = 2'd2;

  typedef struct packed {
    logic               mode;
    logic [3:0]         param_index;
    logic signed [31:0] param_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               last_point;
  } item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               last_out;
  } result_t;

  typedef struct packed {
    logic        is_load;
    logic [3:0]  idx;
    logic [31:0] val;
    logic        last;
  } side_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > 40'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -40'sd2147483648) r = 32'sh8000_0000;
    else r = v[COORD_W-1:0];
    return r;
  endfunction

endpackage

FILE: rtl/ppr_wrap.sv
module ppr_wrap #(
  parameter int IN_W = 33
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic signed [IN_W-1:0]     in_val [3],
  input  ppr_pkg::side_t             in_side,
  input  logic [ppr_pkg::LEN_W-1:0]  len [3],
  output logic                       out_valid,
  output logic signed [ppr_pkg::COORD_W-1:0] out_val [3],
  output ppr_pkg::side_t             out_side
);
  import ppr_pkg::*;

  localparam int NST = IN_W + 1;

  logic             st_valid [NST];
  side_t            st_side  [NST];
  logic             st_sign  [NST][NUM_AXES];
  logic [IN_W-1:0]  st_mag   [NST][NUM_AXES];
  logic [LEN_W-1:0] st_rem   [NST][NUM_AXES];

  logic [LEN_W:0]   shifted  [IN_W][NUM_AXES];
  logic [LEN_W-1:0] rem_next [IN_W][NUM_AXES];

  logic                      f1_valid;
  side_t                     f1_side;
  logic                      f1_sign [NUM_AXES];
  logic [IN_W-1:0]           f1_mag  [NUM_AXES];
  logic signed [COORD_W-1:0] f1_r    [NUM_AXES];

  always_comb begin
    for (int s = 0; s < IN_W; s++) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        shifted[s][i] = {st_rem[s][i], st_mag[s][i][IN_W-1-s]};
        if (shifted[s][i] >= {1'b0, len[i]}) begin
          rem_next[s][i] = LEN_W'(shifted[s][i] - {1'b0, len[i]});
        end else begin
          rem_next[s][i] = shifted[s][i][LEN_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NST; s++) begin
        st_valid[s] <= 1'b0;
      end
    end else if (en) begin
      st_valid[0] <= in_valid;
      for (int s = 0; s < IN_W; s++) begin
        st_valid[s+1] <= st_valid[s];
      end
    end
    if (en) begin
      st_side[0] <= in_side;
      for (int i = 0; i < NUM_AXES; i++) begin
        st_sign[0][i] <= in_val[i][IN_W-1];
        st_mag[0][i]  <= in_val[i][IN_W-1] ? IN_W'(-in_val[i]) : IN_W'(in_val[i]);
        st_rem[0][i]  <= '0;
      end
      for (int s = 0; s < IN_W; s++) begin
        st_side[s+1] <= st_side[s];
        for (int i = 0; i < NUM_AXES; i++) begin
          st_sign[s+1][i] <= st_sign[s][i];
          st_mag[s+1][i]  <= st_mag[s][i];
          st_rem[s+1][i]  <= rem_next[s][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      f1_valid  <= st_valid[NST-1];
      out_valid <= f1_valid;
    end
    if (en) begin
      f1_side  <= st_side[NST-1];
      out_side <= f1_side;
      for (int i = 0; i < NUM_AXES; i++) begin
        f1_sign[i] <= st_sign[NST-1][i];
        f1_mag[i]  <= st_mag[NST-1][i];
        if ({st_rem[NST-1][i], 1'b0} >= {1'b0, len[i]}) begin
          f1_r[i] <= {1'b0, st_rem[NST-1][i]} - {1'b0, len[i]};
        end else begin
          f1_r[i] <= {1'b0, st_rem[NST-1][i]};
        end
        if (len[i] == '0) begin
          out_val[i] <= sat32(SAT_W'(f1_sign[i] ? -$signed({1'b0, f1_mag[i]})
                                                :  $signed({1'b0, f1_mag[i]})));
        end else begin
          out_val[i] <= f1_sign[i] ? -f1_r[i] : f1_r[i];
        end
      end
    end
  end

endmodule

FILE: rtl/ppr_rot.sv
module ppr_rot (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [ppr_pkg::COORD_W-1:0] in_v [3],
  input  ppr_pkg::side_t                     in_side,
  output logic                               out_valid,
  output logic signed [ppr_pkg::ACC_W-1:0]   out_acc [3],
  output ppr_pkg::side_t                     out_side
);
  import ppr_pkg::*;

  logic signed [COORD_W-1:0] matrix [MAT_DEPTH];
  logic signed [COORD_W-1:0] piv    [PIVOT_DEPTH];

  logic                      p_valid;
  side_t                     p_side;
  logic signed [PROD_W-1:0]  p [MAT_DEPTH];

  logic                      r_valid;
  side_t                     r_side;
  logic signed [RND_W-1:0]   rnd [MAT_DEPTH];

  logic                      s_valid;
  side_t                     s_side;
  logic signed [ACC_W-1:0]   s01 [NUM_AXES];
  logic signed [ACC_W-1:0]   spv [NUM_AXES];

  logic [3:0] poff;

  assign poff = r_side.idx - 4'(PIVOT_BASE);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAT_DEPTH; k++) begin
        matrix[k] <= (k % 4 == 0) ? MAT_ONE : '0;
      end
    end else if (en && in_valid && in_side.is_load && in_side.idx < 4'(MAT_DEPTH)) begin
      matrix[in_side.idx] <= in_side.val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIVOT_DEPTH; i++) begin
        piv[i] <= '0;
      end
    end else if (en && r_valid && r_side.is_load && r_side.idx >= 4'(PIVOT_BASE)
                 && r_side.idx < 4'(PIVOT_BASE + PIVOT_DEPTH)) begin
      piv[poff[1:0]] <= r_side.val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      r_valid   <= 1'b0;
      s_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p_valid   <= in_valid;
      r_valid   <= p_valid;
      s_valid   <= r_valid;
      out_valid <= s_valid;
    end
    if (en) begin
      p_side   <= in_side;
      r_side   <= p_side;
      s_side   <= r_side;
      out_side <= s_side;
      for (int k = 0; k < MAT_DEPTH; k++) begin
        p[k]   <= PROD_W'(matrix[k]) * PROD_W'(in_v[k % NUM_AXES]);
        rnd[k] <= RND_W'((p[k] + RND_BIAS) >>> MAT_FRAC);
      end
      for (int i = 0; i < NUM_AXES; i++) begin
        s01[i]     <= ACC_W'(rnd[3*i]) + ACC_W'(rnd[3*i+1]);
        spv[i]     <= ACC_W'(rnd[3*i+2]) + ACC_W'(piv[i]);
        out_acc[i] <= s01[i] + spv[i];
      end
    end
  end

endmodule

FILE: rtl/periodic_pivot_rotation.sv
// Rotates streamed 3-D points about a pivot inside a periodic box.
// Input channel item/item_valid/item_ready: mode 0 loads one matrix word
// (index 0-8, Q2.30, row-major) or pivot coordinate (index 9-11, Q16.16)
// and yields no result; mode 1 transforms one point into one result.
// Result channel result/result_valid/result_ready carries the wrapped
// coordinates and the last mark of the point.
// The APB port holds the box lengths at byte addresses 0, 4 and 8; write
// them only while no transaction is in flight.
// Throughput: one transaction per cycle, loads and points alike, while item_ready is high.
// Path of a point: difference register, input wrap, rotation, output wrap.
// Both wraps are remainder pipelines, one bit per stage (33 and 35 stages).
// Loads take effect in order: later points see them, earlier ones do not.
// Reset restores the identity matrix, a zero pivot and boxes of 100.0.
// When the receiver stalls, an output register and one skid entry hold
// results; once the skid entry is full the whole pipeline holds and
// item_ready drops, so nothing is lost or repeated.
module periodic_pivot_rotation #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  ppr_pkg::item_t  item,
  output logic            result_valid,
  input  logic            result_ready,
  output ppr_pkg::result_t result,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import ppr_pkg::*;

  localparam logic [LEN_W-1:0] BOX_RESET = LEN_W'(BOX_RESET_UNITS << COORD_FRAC_BITS);

  logic [LEN_W-1:0]          box_len [NUM_AXES];
  logic signed [COORD_W-1:0] piv_front [PIVOT_DEPTH];

  logic                      en;
  logic                      accept;
  side_t                     item_side;
  logic [3:0]                poff;

  logic                      d_valid;
  side_t                     d_side;
  logic signed [DIFF_W-1:0]  d [NUM_AXES];

  logic                      w1_valid;
  side_t                     w1_side;
  logic signed [COORD_W-1:0] w1_v [NUM_AXES];

  logic                      rot_valid;
  side_t                     rot_side;
  logic signed [ACC_W-1:0]   rot_acc [NUM_AXES];

  logic                      fin_valid;
  side_t                     fin_side;
  logic signed [COORD_W-1:0] fin_v [NUM_AXES];

  logic                      skid_valid;
  result_t                   skid;
  result_t                   fin_result;
  logic                      fin_point;

  assign pready = 1'b1;
  assign en     = !skid_valid;
  assign item_ready = en;
  assign accept = item_valid && item_ready;
  assign poff   = item.param_index - 4'(PIVOT_BASE);

  assign item_side = '{is_load: item.mode == MODE_LOAD, idx: item.param_index,
                       val: item.param_value, last: item.last_point};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        box_len[i] <= BOX_RESET;
      end
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_BOX_X: box_len[0] <= pwdata[LEN_W-1:0];
        REG_BOX_Y: box_len[1] <= pwdata[LEN_W-1:0];
        REG_BOX_Z: box_len[2] <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BOX_X: prdata = {1'b0, box_len[0]};
      REG_BOX_Y: prdata = {1'b0, box_len[1]};
      REG_BOX_Z: prdata = {1'b0, box_len[2]};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIVOT_DEPTH; i++) begin
        piv_front[i] <= '0;
      end
    end else if (accept && item.mode == MODE_LOAD && item.param_index >= 4'(PIVOT_BASE)
                 && item.param_index < 4'(PIVOT_BASE + PIVOT_DEPTH)) begin
      piv_front[poff[1:0]] <= item.param_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= item_valid;
    end
    if (en) begin
      d_side <= item_side;
      d[0]   <= DIFF_W'(item.point_x) - DIFF_W'(piv_front[0]);
      d[1]   <= DIFF_W'(item.point_y) - DIFF_W'(piv_front[1]);
      d[2]   <= DIFF_W'(item.point_z) - DIFF_W'(piv_front[2]);
    end
  end

  ppr_wrap #(.IN_W(DIFF_W)) u_wrap_in (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(d_valid), .in_val(d), .in_side(d_side), .len(box_len),
    .out_valid(w1_valid), .out_val(w1_v), .out_side(w1_side)
  );

  ppr_rot u_rot (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(w1_valid), .in_v(w1_v), .in_side(w1_side),
    .out_valid(rot_valid), .out_acc(rot_acc), .out_side(rot_side)
  );

  ppr_wrap #(.IN_W(ACC_W)) u_wrap_out (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(rot_valid), .in_val(rot_acc), .in_side(rot_side), .len(box_len),
    .out_valid(fin_valid), .out_val(fin_v), .out_side(fin_side)
  );

  assign fin_point  = en && fin_valid && !fin_side.is_load;
  assign fin_result = '{out_x: fin_v[0], out_y: fin_v[1], out_z: fin_v[2],
                        last_out: fin_side.last};

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (fin_point) begin
      if (result_valid && !result_ready) begin
        skid_valid <= 1'b1;
      end else begin
        result_valid <= 1'b1;
      end
    end else if (result_ready) begin
      result_valid <= skid_valid;
      skid_valid   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_point) begin
      if (result_valid && !result_ready) begin
        skid <= fin_result;
      end else begin
        result <= fin_result;
      end
    end else if (result_ready && skid_valid) begin
      result <= skid;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry holds data while output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(result_valid && !result_ready))
    else $error("skid entry filled without a stalled output");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && skid_valid |=> result_valid)
    else $error("skid entry dropped on drain");

endmodule
